### hw/rtl/rcd_pkg.sv
// Package for the RC5 infrared edge decoder.
// Holds the request and result codes, the queued operation type and the frame constants.
// No dependencies.
package rcd_pkg;

	typedef enum logic {
		EV_EDGE    = 1'b0,
		EV_TIMEOUT = 1'b1
	} ev_t;

	typedef enum logic [1:0] {
		CLS_INVALID = 2'd0,
		CLS_ONE     = 2'd1,
		CLS_TWO     = 2'd2
	} cls_t;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_FRAME   = 2'd1,
		ST_TIMING  = 2'd2,
		ST_NOFRAME = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_BIT_TICKS      = 2'd0,
		CFG_TOLERANCE      = 2'd1,
		CFG_ADDRESS_FILTER = 2'd2
	} cfg_idx_t;

	// One classified request as it travels from the front to the back.
	typedef struct packed {
		ev_t  ev;
		cls_t cls;
	} op_t;

	localparam logic [7:0] AGC_MIN    = 8'h30;
	localparam logic [7:0] ANY_ADDR   = 8'h80;
	localparam logic [5:0] HALF_FULL  = 6'd27;
	localparam logic [5:0] HALF_SHORT = 6'd26;
	localparam logic [5:0] HALF_MAX   = 6'd63;

	localparam logic [7:0] BIT_TICKS_RST      = 8'd68;
	localparam logic [5:0] TOLERANCE_RST      = 6'd11;
	localparam logic [7:0] ADDRESS_FILTER_RST = 8'd128;

endpackage

### hw/rtl/rcd_in_if.sv
// Input channel of the RC5 infrared edge decoder: edge and timeout requests.
// No dependencies.
interface rcd_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] edge_ticks;

	modport source (output valid, output func, output edge_ticks, input ready);
	modport sink   (input valid, input func, input edge_ticks, output ready);
endinterface

### hw/rtl/rcd_out_if.sv
// Output channel of the RC5 infrared edge decoder: one result per request.
// No dependencies.
interface rcd_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [5:0] command;
	logic [4:0] address;
	logic       toggle;

	modport source (output valid, output status, output command, output address,
		output toggle, input ready);
	modport sink   (input valid, input status, input command, input address,
		input toggle, output ready);
endinterface

### hw/rtl/rcd_classify.sv
// Front end of the RC5 decoder: turns a request into a classified operation.
// Depends on rcd_pkg.
module rcd_classify
	import rcd_pkg::*;
(
	input  logic       func,
	input  logic [7:0] edge_ticks,
	input  logic [7:0] bit_ticks,
	input  logic [5:0] tolerance,
	output op_t        op
);

	logic signed [9:0] t_s, whole_s, half_s, dev_s;

	assign t_s     = $signed({2'b00, edge_ticks});
	assign whole_s = $signed({2'b00, bit_ticks});
	assign half_s  = $signed({3'b000, bit_ticks[7:1]});
	assign dev_s   = $signed({4'b0000, tolerance});

	always_comb begin
		op.ev = (func == 1'b1) ? EV_TIMEOUT : EV_EDGE;
		if (t_s > whole_s + dev_s) begin
			op.cls = CLS_INVALID;
		end else if (t_s < half_s - dev_s) begin
			op.cls = CLS_INVALID;
		end else if (t_s > whole_s - dev_s) begin
			op.cls = CLS_TWO;
		end else if (t_s > half_s + dev_s) begin
			op.cls = CLS_INVALID;
		end else begin
			op.cls = CLS_ONE;
		end
	end

endmodule

### hw/rtl/rcd_queue.sv
// Small FIFO that decouples the classifier from the frame engine.
// Depends on rcd_pkg.
module rcd_queue
	import rcd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output op_t  head_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head_op   = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count beyond depth");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("push without pop did not grow the queue");

endmodule

### hw/rtl/rcd_exec.sv
// Back end of the RC5 decoder: frame state, timeout decode and the output register.
// Depends on rcd_pkg and rcd_out_if.
module rcd_exec
	import rcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       op_valid,
	input  op_t        op,
	output logic       op_pop,
	input  logic [7:0] address_filter,
	rcd_out_if.source  out_ch
);

	logic [15:0] frame_q;
	logic [5:0]  half_q;
	logic        seen_q, parity_q, blocked_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [5:0]  command_q;
	logic [4:0]  address_q;
	logic        toggle_q;

	logic [5:0]  half_a, half_b;
	logic [15:0] frame_a, frame_b, frame_t;
	logic [4:0]  adr_t;
	logic        agc_ok, addr_ok, frame_ok;

	assign op_pop = op_valid && (!out_valid_q || out_ch.ready);

	// Two half-bit steps of the shift register; a two-half-bit interval takes both.
	always_comb begin
		half_a  = (half_q != HALF_MAX) ? half_q + 1'b1 : half_q;
		frame_a = half_a[0] ? {frame_q[14:0], parity_q} : frame_q;
		half_b  = (half_a != HALF_MAX) ? half_a + 1'b1 : half_a;
		frame_b = half_b[0] ? {frame_a[14:0], parity_q} : frame_a;
	end

	// Timeout decode: a frame that stopped one half-bit short gets its last bit completed.
	always_comb begin
		frame_t  = (half_q == HALF_SHORT) ? {frame_q[14:0], 1'b0} : frame_q;
		agc_ok   = ((half_q == HALF_SHORT) || (half_q == HALF_FULL))
			&& (frame_t[15:8] >= AGC_MIN);
		adr_t    = frame_t[10:6];
		addr_ok  = address_filter[7] || (address_filter == {3'b000, adr_t});
		frame_ok = agc_ok && addr_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q     <= '0;
			half_q      <= '0;
			seen_q      <= 1'b0;
			parity_q    <= 1'b0;
			blocked_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (op_pop) begin
				if (op.ev == EV_TIMEOUT) begin
					half_q    <= '0;
					seen_q    <= 1'b0;
					parity_q  <= 1'b0;
					blocked_q <= 1'b0;
				end else if (!blocked_q) begin
					parity_q <= ~parity_q;
					if (!seen_q) begin
						seen_q  <= 1'b1;
						frame_q <= '0;
					end else begin
						case (op.cls)
							CLS_ONE: begin
								half_q  <= half_a;
								frame_q <= frame_a;
							end
							CLS_TWO: begin
								half_q  <= half_b;
								frame_q <= frame_b;
							end
							default: begin
								blocked_q <= 1'b1;
								half_q    <= '0;
							end
						endcase
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			if (op.ev == EV_TIMEOUT && frame_ok) begin
				status_q  <= ST_FRAME;
				command_q <= frame_t[5:0];
				address_q <= adr_t;
				toggle_q  <= frame_t[11];
			end else begin
				command_q <= '0;
				address_q <= '0;
				toggle_q  <= 1'b0;
				if (op.ev == EV_TIMEOUT) begin
					status_q <= ST_NOFRAME;
				end else if (!blocked_q && seen_q && op.cls != CLS_ONE
						&& op.cls != CLS_TWO) begin
					status_q <= ST_TIMING;
				end else begin
					status_q <= ST_NONE;
				end
			end
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.status  = status_q;
	assign out_ch.command = command_q;
	assign out_ch.address = address_q;
	assign out_ch.toggle  = toggle_q;

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.ev == EV_TIMEOUT) |=> (!seen_q && !blocked_q && half_q == '0))
		else $error("decoder did not rearm after a timeout");

	a_blocked_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(op_pop && op.ev == EV_EDGE && blocked_q) |=> ($stable(frame_q) && $stable(parity_q)))
		else $error("blocked edge changed the frame state");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_FRAME) |-> (command_q == '0 && address_q == '0
		&& !toggle_q)) else $error("result payload set without an accepted frame");

endmodule

### hw/rtl/rc5_ir_edge_decoder.sv
// Top level of the RC5 infrared edge decoder.
// Depends on rcd_pkg, rcd_in_if, rcd_out_if, rcd_classify, rcd_queue and rcd_exec.
//
// The decoder takes one request per clock cycle while its FIFO has room, and returns
// exactly one result for every request, in order. A request is either a line edge,
// carrying the timer ticks since the previous edge, or a frame timeout. The front end
// compares the interval against the bit_ticks and tolerance registers and tags it as
// one half-bit, two half-bits or a timing error; the tagged request then waits in a
// short FIFO (QUEUE_DEPTH entries) until the frame engine takes it. The frame engine
// holds the 16-bit shift register, the half-bit count and the blocking flag, and on a
// timeout it completes a short frame, checks the AGC bits and the address filter, and
// reports command, address and toggle. The frame engine takes one request per cycle
// while its output register is free or being read. A request is written into the
// FIFO and then moves into the output register, which drives the result on the output
// channel. When the output side stalls, the FIFO absorbs up to QUEUE_DEPTH further
// requests before input ready drops. Configuration writes land on the next clock edge
// and must only be made while no request is in flight.
module rc5_ir_edge_decoder
	import rcd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	rcd_in_if.sink     in_ch,
	rcd_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0] bit_ticks_q;
	logic [5:0] tolerance_q;
	logic [7:0] address_filter_q;

	op_t  cls_op, head_op;
	logic q_full, q_not_empty, q_pop;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q      <= BIT_TICKS_RST;
			tolerance_q      <= TOLERANCE_RST;
			address_filter_q <= ADDRESS_FILTER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BIT_TICKS:      bit_ticks_q      <= cfg_data;
				CFG_TOLERANCE:      tolerance_q      <= cfg_data[5:0];
				CFG_ADDRESS_FILTER: address_filter_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front end: classification is stateless, so it sits right on the input channel.
	rcd_classify u_classify (
		.func       (in_ch.func),
		.edge_ticks (in_ch.edge_ticks),
		.bit_ticks  (bit_ticks_q),
		.tolerance  (tolerance_q),
		.op         (cls_op)
	);

	// The input request is taken whenever the FIFO has room.
	assign in_ch.ready = !q_full;

	rcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_ch.valid),
		.push_op   (cls_op),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_op   (head_op)
	);

	// Back end: frame state and the registered result.
	rcd_exec u_exec (
		.clk            (clk),
		.arst_n         (arst_n),
		.op_valid       (q_not_empty),
		.op             (head_op),
		.op_pop         (q_pop),
		.address_filter (address_filter_q),
		.out_ch         (out_ch)
	);

endmodule
